[rtl/sts_pkg.sv]
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants of the line steering block
// fixed-point constants, register map, queue item and state encoding
// ----------------------------------------------------------------------------
package sts_pkg;

  // input sample width default and normalisation
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int BLACK_LEVEL     = 1100;
  localparam int WHITE_LEVEL     = 4095;
  localparam int SPAN            = WHITE_LEVEL - BLACK_LEVEL;
  localparam int NORM_BITS       = 12;

  // error scaling: e = mag * ERR_NUM / SPAN, Q9.8
  localparam int ERR_SCALE   = 510;
  localparam int ERR_NUM     = ERR_SCALE * 256;
  localparam int T_BITS      = 29;
  localparam int RECIP_SHIFT = 40;
  localparam int RECIP_BITS  = 29;
  localparam logic [RECIP_BITS-1:0] RECIP_MULT =
    RECIP_BITS'((64'd1 << RECIP_SHIFT) / SPAN);
  localparam int Q_BITS = 17;
  localparam int E_BITS = 18;
  localparam int D_BITS = 19;

  // shared multiplier and pd sum
  localparam int MUL_BITS  = T_BITS + 1;
  localparam int PROD_BITS = 2 * MUL_BITS;
  localparam int P_BITS    = 36;
  localparam int FRAC_BITS = 16;
  localparam int O_BITS    = 16;

  // register widths and resets
  localparam int SPEED_BITS = 15;
  localparam int BASE_BITS  = 14;
  localparam int GAIN_BITS  = 16;
  localparam int DZ_BITS    = 9;
  localparam logic signed [GAIN_BITS-1:0] KP_RESET = 16'sd256;
  localparam logic signed [GAIN_BITS-1:0] KD_RESET = 16'sd0;
  localparam logic [DZ_BITS-1:0] DZ_RESET = 9'd100;

  // configuration port
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;
  localparam int REG_IDX_BITS  = 3;
  localparam logic [REG_IDX_BITS-1:0] REG_LINE_MODE  = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_BASE_SPEED = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_KP_GAIN    = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_KD_GAIN    = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_DEAD_ZONE  = 3'd4;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic                        line_mode;
    logic [BASE_BITS-1:0]        base_speed;
    logic signed [GAIN_BITS-1:0] kp_gain;
    logic signed [GAIN_BITS-1:0] kd_gain;
    logic [DZ_BITS-1:0]          dead_zone;
  } sts_cfg_t;

  // classified item: sign and magnitude of the sensor difference
  typedef struct packed {
    logic                 neg;
    logic [NORM_BITS-1:0] mag;
  } sts_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sts_qstat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RECIP,
    ST_FIX,
    ST_ERR,
    ST_MULP,
    ST_MULD,
    ST_OUT
  } sts_state_t;

endpackage

[rtl/sts_in_if.sv]
// ----------------------------------------------------------------------------
// sts_in_if: sensor pair channel
// valid/ready channel carrying one left/right sample pair
// ----------------------------------------------------------------------------
interface sts_in_if #(
  parameter int SAMPLE_BITS = sts_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] left_sample;
  logic [SAMPLE_BITS-1:0] right_sample;

  modport source (output valid, left_sample, right_sample, input ready);
  modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

[rtl/sts_out_if.sv]
// ----------------------------------------------------------------------------
// sts_out_if: wheel speed channel
// valid/ready channel carrying one left/right speed pair
// ----------------------------------------------------------------------------
interface sts_out_if;
  logic                            valid;
  logic                            ready;
  logic [sts_pkg::SPEED_BITS-1:0]  left_speed;
  logic [sts_pkg::SPEED_BITS-1:0]  right_speed;

  modport source (output valid, left_speed, right_speed, input ready);
  modport sink   (input valid, left_speed, right_speed, output ready);
endinterface

[rtl/sts_front.sv]
// ----------------------------------------------------------------------------
// sts_front: sample intake and classification
// normalises both samples and queues sign and magnitude of their difference
// ----------------------------------------------------------------------------
module sts_front #(
  parameter int SAMPLE_BITS = sts_pkg::SAMPLE_BITS_DEF
) (
  sts_in_if.sink               in_chan,
  input  logic                 line_mode,
  input  sts_pkg::sts_qstat_t  qstat,
  output logic                 push,
  output sts_pkg::sts_item_t   push_item
);

  localparam int XW =
    ((SAMPLE_BITS > sts_pkg::NORM_BITS) ? SAMPLE_BITS : sts_pkg::NORM_BITS) + 1;

  function automatic logic [sts_pkg::NORM_BITS-1:0] norm(
    input logic [SAMPLE_BITS-1:0] s
  );
    logic [XW-1:0] x;
    logic [XW-1:0] d;
    x = XW'(s);
    d = x - XW'(sts_pkg::BLACK_LEVEL);
    if (x < XW'(sts_pkg::BLACK_LEVEL)) begin
      return '0;
    end else if (d > XW'(sts_pkg::SPAN)) begin
      return sts_pkg::NORM_BITS'(sts_pkg::SPAN);
    end else begin
      return d[sts_pkg::NORM_BITS-1:0];
    end
  endfunction

  logic [sts_pkg::NORM_BITS-1:0] nl;
  logic [sts_pkg::NORM_BITS-1:0] nr;
  logic signed [sts_pkg::NORM_BITS:0] dn;
  logic signed [sts_pkg::NORM_BITS:0] dn_abs;

  assign in_chan.ready = !qstat.full;
  assign push          = in_chan.valid && !qstat.full;

  always_comb begin
    nl = norm(in_chan.left_sample);
    nr = norm(in_chan.right_sample);
    // light line on dark ground flips the sign of the error
    if (line_mode) begin
      dn = signed'({1'b0, nl}) - signed'({1'b0, nr});
    end else begin
      dn = signed'({1'b0, nr}) - signed'({1'b0, nl});
    end
    dn_abs = dn[sts_pkg::NORM_BITS] ? -dn : dn;
    push_item.neg = dn[sts_pkg::NORM_BITS];
    push_item.mag = dn_abs[sts_pkg::NORM_BITS-1:0];
  end

endmodule

[rtl/sts_queue.sv]
// ----------------------------------------------------------------------------
// sts_queue: item queue between front and back
// small circular buffer of classified items
// ----------------------------------------------------------------------------
module sts_queue #(
  parameter int DEPTH = sts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sts_pkg::sts_item_t   push_item,
  input  logic                 pop,
  output sts_pkg::sts_item_t   pop_item,
  output sts_pkg::sts_qstat_t  qstat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sts_pkg::sts_item_t mem [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign qstat.full  = (cnt_r == CW'(DEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign pop_item    = mem[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

[rtl/sts_back.sv]
// ----------------------------------------------------------------------------
// sts_back: error scaling and pd sequencer
// one shared multiplier, reciprocal division, dead zone, pd sum, speed output
// ----------------------------------------------------------------------------
module sts_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sts_pkg::sts_cfg_t    cfg,
  input  sts_pkg::sts_qstat_t  qstat,
  input  sts_pkg::sts_item_t   pop_item,
  output logic                 pop,
  sts_out_if.source            out_chan
);

  localparam int TB = sts_pkg::T_BITS;
  localparam int QB = sts_pkg::Q_BITS;
  localparam int EB = sts_pkg::E_BITS;
  localparam int DB = sts_pkg::D_BITS;
  localparam int MB = sts_pkg::MUL_BITS;
  localparam int PB = sts_pkg::P_BITS;
  localparam int GB = sts_pkg::GAIN_BITS;
  localparam int OB = sts_pkg::O_BITS;
  localparam int BB = sts_pkg::BASE_BITS;
  localparam int FB = sts_pkg::FRAC_BITS;
  localparam int SB = sts_pkg::SPEED_BITS;

  sts_pkg::sts_state_t state_r, state_nxt;

  logic out_valid_r, out_valid_nxt;
  logic load_out;

  logic [TB-1:0]        t_r;
  logic                 neg_r;
  logic [QB-1:0]        q0_r;
  logic [QB-1:0]        q_r;
  logic signed [EB-1:0] e_r;
  logic signed [DB-1:0] diff_r;
  logic signed [EB-1:0] prev_r, prev_nxt;
  logic signed [PB-1:0] pk_r;
  logic signed [PB-1:0] p_r;
  logic [SB-1:0]        left_r;
  logic [SB-1:0]        right_r;

  logic signed [MB-1:0]            mul_a;
  logic signed [MB-1:0]            mul_b;
  logic signed [sts_pkg::PROD_BITS-1:0] prod;

  logic [TB-1:0]        rem;
  logic [QB-1:0]        q_fix;
  logic [QB-1:0]        dz_lim;
  logic signed [EB-1:0] e_val;
  logic signed [DB-1:0] diff_val;
  logic signed [PB-1:0] lim;
  logic signed [PB-1:0] o_full;
  logic signed [OB-1:0] o_val;
  logic signed [OB-1:0] base_s;
  logic signed [OB-1:0] ls;
  logic signed [OB-1:0] rs;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sts_pkg::ST_IDLE:  if (!qstat.empty) state_nxt = sts_pkg::ST_RECIP;
      sts_pkg::ST_RECIP: state_nxt = sts_pkg::ST_FIX;
      sts_pkg::ST_FIX:   state_nxt = sts_pkg::ST_ERR;
      sts_pkg::ST_ERR:   state_nxt = sts_pkg::ST_MULP;
      sts_pkg::ST_MULP:  state_nxt = sts_pkg::ST_MULD;
      sts_pkg::ST_MULD:  state_nxt = sts_pkg::ST_OUT;
      sts_pkg::ST_OUT:   if (load_out) state_nxt = sts_pkg::ST_IDLE;
      default:           state_nxt = sts_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs and multiplier operand select
  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    case (state_r)
      sts_pkg::ST_IDLE: begin
        pop = !qstat.empty;
      end
      sts_pkg::ST_RECIP: begin
        mul_a = {1'b0, t_r};
        mul_b = {{(MB - sts_pkg::RECIP_BITS){1'b0}}, sts_pkg::RECIP_MULT};
      end
      sts_pkg::ST_MULP: begin
        mul_a = {{(MB - GB){cfg.kp_gain[GB-1]}}, cfg.kp_gain};
        mul_b = {{(MB - EB){e_r[EB-1]}}, e_r};
      end
      sts_pkg::ST_MULD: begin
        mul_a = {{(MB - GB){cfg.kd_gain[GB-1]}}, cfg.kd_gain};
        mul_b = {{(MB - DB){diff_r[DB-1]}}, diff_r};
      end
      sts_pkg::ST_OUT: begin
        load_out = !out_valid_r || out_chan.ready;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // correction step of the reciprocal division
  always_comb begin
    rem   = t_r - TB'(q0_r * sts_pkg::SPAN);
    q_fix = (rem >= TB'(sts_pkg::SPAN)) ? q0_r + 1'b1 : q0_r;
  end

  // dead zone and sign
  always_comb begin
    dz_lim = {cfg.dead_zone, 8'h00};
    if (q_r < dz_lim) begin
      e_val = '0;
    end else if (neg_r) begin
      e_val = EB'(0) - signed'({1'b0, q_r});
    end else begin
      e_val = signed'({1'b0, q_r});
    end
    diff_val = DB'(e_val) - DB'(prev_r);
  end

  // clamp to +/- base speed and truncate toward zero
  always_comb begin
    lim = signed'({{(PB - BB - FB){1'b0}}, cfg.base_speed, {FB{1'b0}}});
    if (p_r > lim) begin
      o_full = signed'(PB'(cfg.base_speed));
    end else if (p_r < -lim) begin
      o_full = -signed'(PB'(cfg.base_speed));
    end else if (p_r[PB-1]) begin
      o_full = (p_r + PB'((1 << FB) - 1)) >>> FB;
    end else begin
      o_full = p_r >>> FB;
    end
    o_val  = o_full[OB-1:0];
    base_s = signed'({{(OB - BB){1'b0}}, cfg.base_speed});
    ls     = base_s - o_val;
    rs     = base_s + o_val;
  end

  always_comb begin
    prev_nxt = prev_r;
    if (state_r == sts_pkg::ST_ERR) begin
      prev_nxt = e_val;
    end
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      t_r   <= TB'(pop_item.mag * sts_pkg::ERR_NUM);
      neg_r <= pop_item.neg;
    end
    if (state_r == sts_pkg::ST_RECIP) begin
      q0_r <= prod[sts_pkg::RECIP_SHIFT +: QB];
    end
    if (state_r == sts_pkg::ST_FIX) begin
      q_r <= q_fix;
    end
    if (state_r == sts_pkg::ST_ERR) begin
      e_r    <= e_val;
      diff_r <= diff_val;
    end
    if (state_r == sts_pkg::ST_MULP) begin
      pk_r <= prod[PB-1:0];
    end
    if (state_r == sts_pkg::ST_MULD) begin
      p_r <= pk_r + prod[PB-1:0];
    end
    if (load_out) begin
      left_r  <= ls[SB-1:0];
      right_r <= rs[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sts_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      prev_r      <= prev_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.left_speed  = left_r;
  assign out_chan.right_speed = right_r;

endmodule

[rtl/two_sensor_line_pd_steering.sv]
// ----------------------------------------------------------------------------
// two_sensor_line_pd_steering: two-sensor line follower pd steering
// an accepted sample pair passes the queue, then the back states recip, fix,
//   err, mulp, muld and out, which registers the speed pair; the back
//   sequencer runs the shared multiplier three times (reciprocal, kp term, kd term)
// the front and a 2-entry queue take new pairs while the back is busy
// reset: synchronous active-low rst_n clears control state, previous error
//   and registers (kp 256, dead zone 100, others 0); no clearing pass
// ----------------------------------------------------------------------------
module two_sensor_line_pd_steering #(
  parameter int SAMPLE_BITS = sts_pkg::SAMPLE_BITS_DEF,
  parameter int QUEUE_DEPTH = sts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  sts_in_if.sink                             in_chan,
  sts_out_if.source                          out_chan,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sts_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [sts_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [sts_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                               pready
);

  localparam int DW = sts_pkg::CFG_DATA_BITS;

  // configuration register file
  sts_pkg::sts_cfg_t cfg_r, cfg_nxt;
  logic [sts_pkg::REG_IDX_BITS-1:0] reg_idx;
  logic cfg_wr;

  // front to queue to back
  logic                push;
  logic                pop;
  sts_pkg::sts_item_t  push_item;
  sts_pkg::sts_item_t  pop_item;
  sts_pkg::sts_qstat_t qstat;

  // registers sit on word addresses, low address bits are ignored
  assign reg_idx = paddr[sts_pkg::CFG_ADDR_BITS-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  // register write decode, unknown indexes drop the transfer
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        sts_pkg::REG_LINE_MODE:  cfg_nxt.line_mode  = pwdata[0];
        sts_pkg::REG_BASE_SPEED: cfg_nxt.base_speed = pwdata[sts_pkg::BASE_BITS-1:0];
        sts_pkg::REG_KP_GAIN:    cfg_nxt.kp_gain    = pwdata[sts_pkg::GAIN_BITS-1:0];
        sts_pkg::REG_KD_GAIN:    cfg_nxt.kd_gain    = pwdata[sts_pkg::GAIN_BITS-1:0];
        sts_pkg::REG_DEAD_ZONE:  cfg_nxt.dead_zone  = pwdata[sts_pkg::DZ_BITS-1:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  // read-back, zero extended
  always_comb begin
    case (reg_idx)
      sts_pkg::REG_LINE_MODE:  prdata = DW'(cfg_r.line_mode);
      sts_pkg::REG_BASE_SPEED: prdata = DW'(cfg_r.base_speed);
      sts_pkg::REG_KP_GAIN:    prdata = DW'(unsigned'(cfg_r.kp_gain));
      sts_pkg::REG_KD_GAIN:    prdata = DW'(unsigned'(cfg_r.kd_gain));
      sts_pkg::REG_DEAD_ZONE:  prdata = DW'(cfg_r.dead_zone);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_mode  <= 1'b0;
      cfg_r.base_speed <= '0;
      cfg_r.kp_gain    <= sts_pkg::KP_RESET;
      cfg_r.kd_gain    <= sts_pkg::KD_RESET;
      cfg_r.dead_zone  <= sts_pkg::DZ_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: normalise samples, classify the difference, push on each transfer
  sts_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .in_chan   (in_chan),
    .line_mode (cfg_r.line_mode),
    .qstat     (qstat),
    .push      (push),
    .push_item (push_item)
  );

  // decoupling queue, lets input and output stall independently
  sts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .qstat     (qstat)
  );

  // back: scale to q9.8, dead zone, pd sum, clamp, wheel speeds
  sts_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .qstat    (qstat),
    .pop_item (pop_item),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the two-sensor pd steering block
// feeds sensor pairs and apb register writes, works out every wheel speed
// pair with its own model of the steering law and checks each output transfer
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SAMPLE_W        = sts_pkg::SAMPLE_BITS_DEF;
  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 11;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 20;
  localparam int RX_HOLD_CYCLES  = 300;
  localparam int IDLE_PCT        = 23;
  localparam int RANDOM_PHASES   = 8;
  localparam int PAIRS_PER_PHASE = 230;
  localparam int MAX_REPORTS     = 10;

  localparam int IDX_W  = sts_pkg::REG_IDX_BITS;
  localparam int ADDR_W = sts_pkg::CFG_ADDR_BITS;
  localparam int DATA_W = sts_pkg::CFG_DATA_BITS;
  localparam int SPD_W  = sts_pkg::SPEED_BITS;
  localparam int BASE_W = sts_pkg::BASE_BITS;
  localparam int GAIN_W = sts_pkg::GAIN_BITS;
  localparam int DZ_W   = sts_pkg::DZ_BITS;
  localparam int ERR_W  = sts_pkg::E_BITS;

  // steering law constants
  localparam longint DARK_LEVEL = 1100;
  localparam longint LIGHT_SPAN = 2995;
  localparam longint ERR_GAIN   = 510 * 256;
  localparam longint Q16_ONE    = 65536;

  // register slots above the last real register, writes there do nothing
  localparam logic [IDX_W-1:0] REG_SPARE_FIRST = IDX_W'(sts_pkg::REG_DEAD_ZONE + 1);
  localparam logic [IDX_W-1:0] REG_SPARE_LAST  = '1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] left_sample;
    logic [SAMPLE_W-1:0] right_sample;
  } sensor_pair_t;

  typedef struct packed {
    logic [SPD_W-1:0] left_speed;
    logic [SPD_W-1:0] right_speed;
  } speed_pair_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  sts_in_if #(.SAMPLE_BITS(SAMPLE_W)) in_chan ();
  sts_out_if                          out_chan ();

  two_sensor_line_pd_steering #(
    .SAMPLE_BITS(SAMPLE_W)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // model copy of the registers and of the stored error
  sts_pkg::sts_cfg_t       steer_cfg;
  logic signed [ERR_W-1:0] prior_error;

  // sensor pairs waiting for the driver, speed pairs waiting for the dut
  sensor_pair_t pairs_pending[$];
  speed_pair_t  speeds_due[$];

  // handshake bookkeeping shared between the clocked processes
  logic in_taken      = 1'b0;
  int   cycle_count   = 0;
  int   tx_idle_pct   = IDLE_PCT;
  int   rx_idle_pct   = IDLE_PCT;
  int   rx_hold_req   = 0;
  int   rx_hold_seen  = 0;
  int   rx_hold_left  = 0;

  int pairs_accepted = 0;
  int speeds_checked = 0;
  int settings_used  = 0;
  int failures       = 0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // reading after black removal, clamped to the white-black span
  function automatic longint sensor_level(logic [SAMPLE_W-1:0] raw);
    longint lvl;
    lvl = longint'(raw) - DARK_LEVEL;
    if (lvl < 0) begin
      lvl = 0;
    end
    if (lvl > LIGHT_SPAN) begin
      lvl = LIGHT_SPAN;
    end
    return lvl;
  endfunction

  // one step of the steering law: error, dead zone, pd term, clamp, speeds
  function automatic speed_pair_t predict_wheel_speeds(sensor_pair_t pair);
    longint      lvl_l;
    longint      lvl_r;
    longint      diff;
    longint      err;
    longint      mag;
    longint      pd;
    longint      lim;
    longint      ctl;
    longint      base;
    speed_pair_t speeds;
    lvl_l = sensor_level(pair.left_sample);
    lvl_r = sensor_level(pair.right_sample);
    diff  = steer_cfg.line_mode ? (lvl_l - lvl_r) : (lvl_r - lvl_l);
    // q9.8 error, division truncates toward zero
    err = (diff * ERR_GAIN) / LIGHT_SPAN;
    mag = (err < 0) ? -err : err;
    if (mag < longint'(steer_cfg.dead_zone) * 256) begin
      err = 0;
    end
    pd = longint'($signed(steer_cfg.kp_gain)) * err
       + longint'($signed(steer_cfg.kd_gain)) * (err - longint'(prior_error));
    base = longint'(steer_cfg.base_speed);
    lim  = base * Q16_ONE;
    if (pd > lim) begin
      pd = lim;
    end
    if (pd < -lim) begin
      pd = -lim;
    end
    ctl = pd / Q16_ONE;
    speeds.left_speed  = SPD_W'(base - ctl);
    speeds.right_speed = SPD_W'(base + ctl);
    prior_error = ERR_W'(err);
    return speeds;
  endfunction

  // register write as seen by the model, bits above each width dropped
  function automatic void apply_register(logic [IDX_W-1:0] idx,
                                         logic [DATA_W-1:0] data);
    case (idx)
      sts_pkg::REG_LINE_MODE: begin
        steer_cfg.line_mode = data[0];
      end
      sts_pkg::REG_BASE_SPEED: begin
        steer_cfg.base_speed = data[BASE_W-1:0];
      end
      sts_pkg::REG_KP_GAIN: begin
        steer_cfg.kp_gain = data[GAIN_W-1:0];
      end
      sts_pkg::REG_KD_GAIN: begin
        steer_cfg.kd_gain = data[GAIN_W-1:0];
      end
      sts_pkg::REG_DEAD_ZONE: begin
        steer_cfg.dead_zone = data[DZ_W-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  task automatic note_failure(string msg);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitor: input transfers feed the model, output transfers are checked
  // against the oldest speed pair still due
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    speed_pair_t  due;
    sensor_pair_t took;
    cycle_count++;
    in_taken = rst_n && in_chan.valid && in_chan.ready;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      speeds_checked++;
      if (speeds_due.size() == 0) begin
        note_failure($sformatf("speed pair left %0d right %0d with nothing due",
                               out_chan.left_speed, out_chan.right_speed));
      end else begin
        due = speeds_due.pop_front();
        if (out_chan.left_speed !== due.left_speed) begin
          note_failure($sformatf("left_speed expected %0d got %0d",
                                 due.left_speed, out_chan.left_speed));
        end
        if (out_chan.right_speed !== due.right_speed) begin
          note_failure($sformatf("right_speed expected %0d got %0d",
                                 due.right_speed, out_chan.right_speed));
        end
      end
    end
    if (in_taken) begin
      took.left_sample  = in_chan.left_sample;
      took.right_sample = in_chan.right_sample;
      speeds_due.push_back(predict_wheel_speeds(took));
      pairs_accepted++;
    end
  end

  // ---------------------------------------------------------------------------
  // driver: holds an offer until its transfer, then takes the next pending
  // pair or idles at random
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    sensor_pair_t next_pair;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (in_chan.valid && !in_taken) begin
      // offer still open, keep everything steady
    end else if (pairs_pending.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
      next_pair = pairs_pending.pop_front();
      in_chan.valid        <= 1'b1;
      in_chan.left_sample  <= next_pair.left_sample;
      in_chan.right_sample <= next_pair.right_sample;
    end else begin
      in_chan.valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random back-pressure, plus a long hold-off on request that is
  // counted down here so the block backs up and stalls its input
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen = rx_hold_req;
      rx_hold_left = RX_HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // timeout guard
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // apb write: setup cycle, access cycle, register taken at the pready edge
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_register(idx, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // optionally fills the bits above a register's width with noise
  function automatic logic [DATA_W-1:0] with_noise(logic [DATA_W-1:0] value,
                                                   int width, logic noisy);
    logic [DATA_W-1:0] mask;
    mask = (DATA_W'(1) << width) - 1;
    return noisy ? (($urandom() & ~mask) | (value & mask)) : (value & mask);
  endfunction

  task automatic write_setting(logic mode, logic [BASE_W-1:0] base,
                               logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] kd,
                               logic [DZ_W-1:0] dz, logic noisy);
    write_reg(sts_pkg::REG_LINE_MODE, with_noise(DATA_W'(mode), 1, noisy));
    write_reg(sts_pkg::REG_BASE_SPEED, with_noise(DATA_W'(base), BASE_W, noisy));
    write_reg(sts_pkg::REG_KP_GAIN, with_noise(DATA_W'(kp), GAIN_W, noisy));
    write_reg(sts_pkg::REG_KD_GAIN, with_noise(DATA_W'(kd), GAIN_W, noisy));
    write_reg(sts_pkg::REG_DEAD_ZONE, with_noise(DATA_W'(dz), DZ_W, noisy));
    settings_used++;
  endtask

  // sender stops until every due speed pair has come back
  task automatic wait_drained();
    do @(posedge clk);
    while (!(pairs_pending.size() == 0 && !in_chan.valid && speeds_due.size() == 0));
  endtask

  // drained and then left to settle, so the block is idle for writes
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void queue_pair(int left, int right);
    sensor_pair_t pair;
    pair.left_sample  = SAMPLE_W'(left);
    pair.right_sample = SAMPLE_W'(right);
    pairs_pending.push_back(pair);
  endfunction

  // mix of flat random, close pairs around the dead zone, edge readings and readings at or above black
  function automatic void queue_random_pair();
    int edges[6] = '{0, 1099, 1100, 1101, 4094, 4095};
    int kind;
    int a;
    int b;
    kind = $urandom_range(0, 3);
    case (kind)
      0: begin
        a = $urandom_range(0, 4095);
        b = $urandom_range(0, 4095);
      end
      1: begin
        a = $urandom_range(0, 4095);
        b = a + $urandom_range(0, 1800) - 900;
        if (b < 0) begin
          b = 0;
        end
        if (b > 4095) begin
          b = 4095;
        end
      end
      2: begin
        a = edges[$urandom_range(0, 5)];
        b = $urandom_range(0, 1) ? edges[$urandom_range(0, 5)] : $urandom_range(0, 4095);
      end
      default: begin
        a = $urandom_range(1100, 4095);
        b = $urandom_range(1100, 4095);
      end
    endcase
    if ($urandom_range(0, 1)) begin
      queue_pair(a, b);
    end else begin
      queue_pair(b, a);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int directed_pairs;
    int half;
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] kd;

    rst_n                = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_chan.valid        = 1'b0;
    in_chan.left_sample  = '0;
    in_chan.right_sample = '0;
    out_chan.ready       = 1'b0;

    // model registers at their reset values
    steer_cfg.line_mode  = 1'b0;
    steer_cfg.base_speed = '0;
    steer_cfg.kp_gain    = sts_pkg::KP_RESET;
    steer_cfg.kd_gain    = sts_pkg::KD_RESET;
    steer_cfg.dead_zone  = sts_pkg::DZ_RESET;
    prior_error          = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: zero base speed clamps every output to zero
    @(posedge clk);
    queue_pair(0, 4095);
    queue_pair(4095, 0);
    queue_pair(2600, 2600);
    settle();

    // dark line, moderate gains, negative kd, default dead zone
    write_setting(1'b0, 14'd6000, 16'h0300, 16'hFD80, 9'd100, 1'b0);
    @(posedge clk);
    queue_pair(0, 0);
    queue_pair(4095, 4095);
    queue_pair(0, 4095);
    queue_pair(4095, 0);
    queue_pair(1099, 1101);
    queue_pair(1101, 1099);
    // just over and just under the dead zone, both signs
    queue_pair(1100, 1688);
    queue_pair(1100, 1687);
    queue_pair(1688, 1100);
    queue_pair(1687, 1100);
    // reading below black clamps to zero
    queue_pair(1000, 1688);
    queue_pair(4095, 3507);
    queue_pair(2500, 1200);
    queue_pair(4094, 1101);
    settle();

    // light line, largest gains and base, no dead zone, noise in upper bits
    write_setting(1'b1, 14'h3FFF, 16'h7FFF, 16'h7FFF, 9'd0, 1'b1);
    for (int idx = REG_SPARE_FIRST; idx <= REG_SPARE_LAST; idx++) begin
      write_reg(IDX_W'(idx), $urandom());
    end
    @(posedge clk);
    queue_pair(0, 4095);
    queue_pair(4095, 0);
    queue_pair(1100, 1101);
    queue_pair(1101, 1100);
    queue_pair(2000, 2000);
    queue_pair(1100, 1100);
    settle();
    directed_pairs = pairs_accepted;

    // random part, one register setting per phase
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: write_setting(1'b0, 14'h3FFF, 16'h7FFF, 16'h8000, 9'd0, 1'b1);
        1: write_setting(1'b1, 14'd0, 16'h8000, 16'h7FFF, 9'd510, 1'b1);
        2: write_setting(1'b1, 14'd1, 16'd1, 16'd1, 9'd0, 1'b0);
        default: begin
          kp = $urandom_range(0, 1) ? GAIN_W'($urandom())
                                    : GAIN_W'($urandom_range(0, 2048) - 1024);
          kd = $urandom_range(0, 1) ? GAIN_W'($urandom())
                                    : GAIN_W'($urandom_range(0, 2048) - 1024);
          write_setting(1'($urandom_range(0, 1)), BASE_W'($urandom_range(0, 16383)),
                        kp, kd,
                        DZ_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 510)
                                                          : $urandom_range(0, 160)),
                        1'($urandom_range(0, 1)));
        end
      endcase
      write_reg(IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom());

      // one phase runs with no idling on either side
      tx_idle_pct = (phase == 5) ? 0 : IDLE_PCT;
      rx_idle_pct = tx_idle_pct;

      @(posedge clk);
      // long receiver hold-off while the sender keeps offering
      if (phase == 3) begin
        rx_hold_req++;
      end
      half = PAIRS_PER_PHASE / 2;
      for (int n = 0; n < half; n++) begin
        queue_random_pair();
      end
      // sender pause until everything due has come back
      if (phase == 6) begin
        wait_drained();
      end
      for (int n = half; n < PAIRS_PER_PHASE; n++) begin
        queue_random_pair();
      end
      settle();
    end

    if (speeds_due.size() != 0) begin
      note_failure($sformatf("%0d speed pairs never arrived", speeds_due.size()));
    end
    $display("covered %0d sensor pairs (%0d directed) over %0d register settings",
             pairs_accepted, directed_pairs, settings_used);
    $display("%0d speed pairs checked, %0d mismatches", speeds_checked, failures);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
